FILE: hw/rtl/rme_pkg.sv
// ----------------------------------------------------------------------------
// rme_pkg
// Shared types and constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
`default_nettype none

package rme_pkg;

    localparam int DEF_WIDTH = 16;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 4;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_ENC = 2'd0;
    localparam logic [1:0] REG_DEC = 2'd1;
    localparam logic [1:0] REG_MOD = 2'd2;

    // multiply operations
    localparam logic [1:0] OP_RED = 2'd0;   // message mod n
    localparam logic [1:0] OP_SQR = 2'd1;   // acc * acc
    localparam logic [1:0] OP_MUL = 2'd2;   // acc * base

    typedef struct packed {
        logic       load;
        logic       start;
        logic [1:0] sel;
        logic       shift;
        logic       finish;
    } t_dp_cmd;

    typedef struct packed {
        logic mul_done;
        logic exp_bit;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: hw/rtl/rme_datapath.sv
// ----------------------------------------------------------------------------
// rme_datapath
// Operand registers and a bit-serial interleaved modular multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module rme_datapath
    import rme_pkg::*;
#(
    parameter int WIDTH = DEF_WIDTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_dp_cmd          i_cmd,
    input  wire logic             i_mode,
    input  wire logic [WIDTH-1:0] i_message,
    input  wire logic [WIDTH-1:0] i_enc,
    input  wire logic [WIDTH-1:0] i_dec,
    input  wire logic [WIDTH-1:0] i_modulus,
    output t_dp_stat              o_stat,
    output logic      [WIDTH-1:0] o_value
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_n;
    logic [WIDTH:0]   r_n2;
    logic             r_nz;
    logic [WIDTH-1:0] r_exp;
    logic [WIDTH-1:0] r_base;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_b;
    logic [WIDTH-1:0] r_r;
    logic             r_dest_base;
    logic [CW-1:0]    r_mcnt;
    logic             r_done;
    logic [WIDTH-1:0] r_out;

    logic [WIDTH-1:0] one_in;
    logic [WIDTH-1:0] op_a;
    logic [WIDTH-1:0] op_b;
    logic [WIDTH+1:0] sum;
    logic [WIDTH+1:0] sum_n;
    logic [WIDTH+1:0] sum_n2;
    logic [WIDTH-1:0] n_r;

    assign one_in = {{(WIDTH-1){1'b0}}, (i_modulus != WIDTH'(1))};

    always_comb begin
        case (i_cmd.sel)
            OP_SQR: begin
                op_a = r_acc;
                op_b = r_acc;
            end
            OP_MUL: begin
                op_a = r_base;
                op_b = r_acc;
            end
            default: begin
                op_a = one_in;
                op_b = i_message;
            end
        endcase
    end

    // r < n and a < n, so 2r + a < 3n: at most two subtractions of n
    always_comb begin
        sum    = {r_r, 1'b0} + (r_b[WIDTH-1] ? (WIDTH+2)'(r_a) : '0);
        sum_n  = sum - (WIDTH+2)'(r_n);
        sum_n2 = sum - (WIDTH+2)'(r_n2);
        if (sum >= (WIDTH+2)'(r_n2)) begin
            n_r = sum_n2[WIDTH-1:0];
        end else if (sum >= (WIDTH+2)'(r_n)) begin
            n_r = sum_n[WIDTH-1:0];
        end else begin
            n_r = sum[WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcnt <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_mcnt <= CW'(WIDTH);
            end else if (r_mcnt != '0) begin
                r_mcnt <= r_mcnt - CW'(1);
                if (r_mcnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n   <= i_modulus;
            r_n2  <= {i_modulus, 1'b0};
            r_nz  <= (i_modulus == '0);
            r_exp <= i_mode ? i_dec : i_enc;
            r_acc <= one_in;
        end else if (i_cmd.shift) begin
            r_exp <= {r_exp[WIDTH-2:0], 1'b0};
        end
        if (i_cmd.start) begin
            r_a         <= op_a;
            r_b         <= op_b;
            r_r         <= '0;
            r_dest_base <= (i_cmd.sel == OP_RED);
        end else if (r_mcnt != '0) begin
            r_r <= n_r;
            r_b <= {r_b[WIDTH-2:0], 1'b0};
            if (r_mcnt == CW'(1)) begin
                if (r_dest_base) begin
                    r_base <= n_r;
                end else begin
                    r_acc <= n_r;
                end
            end
        end
        if (i_cmd.finish) begin
            r_out <= r_nz ? '0 : r_acc;
        end
    end

    assign o_stat.mul_done = r_done;
    assign o_stat.exp_bit  = r_exp[WIDTH-1];
    assign o_value         = r_out;

endmodule

`default_nettype wire

FILE: hw/rtl/rme_ctrl.sv
// ----------------------------------------------------------------------------
// rme_ctrl
// Sequencer for square-and-multiply over the exponent bits, msb first.
// ----------------------------------------------------------------------------
`default_nettype none

module rme_ctrl
    import rme_pkg::*;
#(
    parameter int WIDTH = DEF_WIDTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    localparam int BW = $clog2(WIDTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_SQR  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]    r_state;
    logic [2:0]    n_state;
    logic [BW-1:0] r_bit;
    logic [BW-1:0] n_bit;
    logic          r_out_valid;
    logic          n_out_valid;
    t_dp_cmd       cmd;

    always_comb begin
        n_state     = r_state;
        n_bit       = r_bit;
        cmd         = '0;
        cmd.sel     = OP_SQR;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load  = 1'b1;
                    cmd.start = 1'b1;
                    cmd.sel   = OP_RED;
                    n_bit     = BW'(WIDTH - 1);
                    n_state   = S_RED;
                end
            end
            S_RED: begin
                if (i_stat.mul_done) begin
                    cmd.start = 1'b1;
                    n_state   = S_SQR;
                end
            end
            S_SQR, S_MUL: begin
                if (i_stat.mul_done) begin
                    if (r_state == S_SQR && i_stat.exp_bit) begin
                        cmd.start = 1'b1;
                        cmd.sel   = OP_MUL;
                        n_state   = S_MUL;
                    end else if (r_bit == '0) begin
                        n_state = S_DONE;
                    end else begin
                        // next exponent bit
                        cmd.shift = 1'b1;
                        cmd.start = 1'b1;
                        n_bit     = r_bit - BW'(1);
                        n_state   = S_SQR;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.finish = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

`default_nettype wire

FILE: hw/rtl/rsa_modular_exponentiation.sv
// ----------------------------------------------------------------------------
// rsa_modular_exponentiation
// RSA square-and-multiply modular exponentiation with an APB register port.
// ----------------------------------------------------------------------------
// Each request raises message mod n to the encrypt (tuser 0) or decrypt
// (tuser 1) exponent modulo the modulus register and returns one result.
// One modular multiply runs bit-serially; the run time of a request grows
// with the number of set exponent bits and is set by the serial multiplier
// that all squares and multiplies share. A modulus of zero or one yields 0.
// A new request is taken while a finished result still waits on the output.
`default_nettype none

module rsa_modular_exponentiation
    import rme_pkg::*;
#(
    parameter  int WIDTH   = DEF_WIDTH,
    localparam int TDATA_W = ((WIDTH + 7) / 8) * 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // apb register port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [APB_AW-1:0]  paddr,
    input  wire logic [APB_DW-1:0]  pwdata,
    output logic      [APB_DW-1:0]  prdata,
    output logic                    pready,
    // request stream
    input  wire logic               i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  wire logic [TDATA_W-1:0] i_s_axis_tdata,  // [WIDTH-1:0] message
    input  wire logic               i_s_axis_tuser,  // [0] mode
    // result stream
    output logic                    o_m_axis_tvalid,
    input  wire logic               i_m_axis_tready,
    output logic      [TDATA_W-1:0] o_m_axis_tdata   // [WIDTH-1:0] value
);

    logic [WIDTH-1:0] r_enc;
    logic [WIDTH-1:0] r_dec;
    logic [WIDTH-1:0] r_mod;
    logic             cfg_wr;
    t_dp_cmd          cmd;
    t_dp_stat         stat;
    logic [WIDTH-1:0] value;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc <= WIDTH'(1);
            r_dec <= WIDTH'(1);
            r_mod <= WIDTH'(1);
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_ENC: r_enc <= pwdata[WIDTH-1:0];
                REG_DEC: r_dec <= pwdata[WIDTH-1:0];
                REG_MOD: r_mod <= pwdata[WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ENC: prdata = APB_DW'(r_enc);
            REG_DEC: prdata = APB_DW'(r_dec);
            REG_MOD: prdata = APB_DW'(r_mod);
            default: prdata = '0;
        endcase
    end

    rme_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    rme_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_mode    (i_s_axis_tuser),
        .i_message (i_s_axis_tdata[WIDTH-1:0]),
        .i_enc     (r_enc),
        .i_dec     (r_dec),
        .i_modulus (r_mod),
        .o_stat    (stat),
        .o_value   (value)
    );

    assign o_m_axis_tdata = TDATA_W'(value);

    // busy right after a request is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("request taken while previous one still in progress");

    // a new result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("result register overwritten");

    // multiplier only completes while a request is in progress
    a_done_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.mul_done |-> !o_s_axis_tready)
        else $error("multiply completed while idle");

    // a multiply is launched only on a multiplier completion or a new request
    a_start_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start |-> (stat.mul_done || cmd.load))
        else $error("multiply started without cause");

endmodule

`default_nettype wire

FILE: tb/tb_rsa_modular_exponentiation.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rsa_modular_exponentiation
// Self-checking bench for the square-and-multiply modular exponentiation block.
// A short table of requests and register writes comes first; some rows carry a
// typed result and the rest are predicted. Random phases follow. They vary the
// keys and the handshake idling, and one phase holds the result side off long
// enough to back the request side up. Every result is compared in order with
// its typed value or with a local exponentiation model.
// ----------------------------------------------------------------------------

module tb_rsa_modular_exponentiation;
    import rme_pkg::*;

    localparam int W           = DEF_WIDTH;
    localparam int TDATA_W     = ((W + 7) / 8) * 8;
    localparam int DIR_ROWS    = 31;
    localparam int NUM_PHASES  = 9;
    localparam int PHASE_REQS  = 110;
    localparam int HOLD_CYCLES = 4000;
    localparam int DRAIN_WAIT  = 600;
    localparam int CYCLE_LIMIT = 6000000;

    // register index past the end of the map, writes are dropped
    localparam logic [1:0] REG_NONE = 2'd3;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    typedef enum logic [1:0] {
        ROW_CFG,    // register write
        ROW_REQ,    // request, result from the model
        ROW_CHK     // request, result typed in the row
    } t_row_kind;

    typedef struct packed {
        t_row_kind      kind;
        logic [1:0]     reg_idx;
        logic [31:0]    wdata;
        logic           mode;
        logic [W-1:0]   message;
        logic [W-1:0]   value;
    } t_stim_row;

    typedef struct {
        logic           mode;
        logic [W-1:0]   message;
        logic [W-1:0]   value;
    } t_pow_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;
    logic               i_s_axis_tvalid;
    logic               o_s_axis_tready;
    logic [TDATA_W-1:0] i_s_axis_tdata;     // [W-1:0] message
    logic               i_s_axis_tuser;     // [0] mode
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready;
    logic [TDATA_W-1:0] o_m_axis_tdata;     // [W-1:0] value

    logic [W-1:0]       enc_exp;
    logic [W-1:0]       dec_exp;
    logic [W-1:0]       mod_n;

    t_pow_result        pending_pow [$];
    int                 err_count   = 0;
    int                 cycle_count = 0;
    int                 tx_idle_pct = 0;
    int                 rx_stall_pct = 0;
    logic               hold_req    = 1'b0;
    logic               hold_done   = 1'b0;
    int                 hold_left   = 0;

    t_stim_row dir_tab [0:DIR_ROWS-1] = '{
        // modulus of one out of reset
        '{ROW_CHK, REG_ENC, 32'h0, MODE_ENC, 16'h1234, 16'h0000},
        '{ROW_CHK, REG_ENC, 32'h0, MODE_DEC, 16'hFFFF, 16'h0000},
        '{ROW_CFG, REG_MOD, 32'h0000_FFFF, MODE_ENC, 16'h0, 16'h0},
        '{ROW_CFG, REG_DEC, 32'h0000_0000, MODE_ENC, 16'h0, 16'h0},
        '{ROW_CHK, REG_ENC, 32'h0, MODE_ENC, 16'h0000, 16'h0000},
        '{ROW_CHK, REG_ENC, 32'h0, MODE_ENC, 16'hFFFF, 16'h0000},
        '{ROW_CHK, REG_ENC, 32'h0, MODE_ENC, 16'hFFFE, 16'hFFFE},
        // zero exponent gives one
        '{ROW_CHK, REG_ENC, 32'h0, MODE_DEC, 16'd12345, 16'h0001},
        '{ROW_CHK, REG_ENC, 32'h0, MODE_DEC, 16'h0000, 16'h0001},
        '{ROW_CFG, REG_ENC, 32'h0000_FFFF, MODE_ENC, 16'h0, 16'h0},
        '{ROW_CFG, REG_DEC, 32'h0000_FFFF, MODE_ENC, 16'h0, 16'h0},
        '{ROW_CHK, REG_ENC, 32'h0, MODE_DEC, 16'hFFFE, 16'hFFFE},
        '{ROW_REQ, REG_ENC, 32'h0, MODE_ENC, 16'h0002, 16'h0},
        '{ROW_REQ, REG_ENC, 32'h0, MODE_DEC, 16'h8001, 16'h0},
        // modulus of zero
        '{ROW_CFG, REG_MOD, 32'h0000_0000, MODE_ENC, 16'h0, 16'h0},
        '{ROW_CHK, REG_ENC, 32'h0, MODE_ENC, 16'h0005, 16'h0000},
        '{ROW_CHK, REG_ENC, 32'h0, MODE_DEC, 16'hFFFF, 16'h0000},
        // textbook key pair, n = 61 * 53
        '{ROW_CFG, REG_MOD, 32'd3233, MODE_ENC, 16'h0, 16'h0},
        '{ROW_CFG, REG_ENC, 32'd17, MODE_ENC, 16'h0, 16'h0},
        '{ROW_CFG, REG_DEC, 32'd2753, MODE_ENC, 16'h0, 16'h0},
        '{ROW_CHK, REG_ENC, 32'h0, MODE_ENC, 16'd65, 16'd2790},
        '{ROW_CHK, REG_ENC, 32'h0, MODE_DEC, 16'd2790, 16'd65},
        '{ROW_REQ, REG_ENC, 32'h0, MODE_ENC, 16'd4000, 16'h0},
        '{ROW_CHK, REG_ENC, 32'h0, MODE_DEC, 16'd3233, 16'h0000},
        // unmapped index, then a write with junk above the register width
        '{ROW_CFG, REG_NONE, 32'h0000_0007, MODE_ENC, 16'h0, 16'h0},
        '{ROW_CFG, REG_ENC, 32'hABCD_0003, MODE_ENC, 16'h0, 16'h0},
        '{ROW_REQ, REG_ENC, 32'h0, MODE_ENC, 16'h0ABC, 16'h0},
        '{ROW_REQ, REG_ENC, 32'h0, MODE_DEC, 16'd1234, 16'h0},
        '{ROW_CFG, REG_MOD, 32'h0000_0001, MODE_ENC, 16'h0, 16'h0},
        '{ROW_CHK, REG_ENC, 32'h0, MODE_DEC, 16'h5555, 16'h0000},
        '{ROW_CHK, REG_ENC, 32'h0, MODE_ENC, 16'hAAAA, 16'h0000}
    };

    rsa_modular_exponentiation #(
        .WIDTH (W)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // msb-first square-and-multiply, products held at double width
    function automatic logic [W-1:0] mod_pow_predict(
        input logic [W-1:0] base,
        input logic [W-1:0] expo,
        input logic [W-1:0] n
    );
        logic [2*W-1:0] nn;
        logic [2*W-1:0] acc;
        logic [2*W-1:0] b;
        nn = n;
        if (nn == 0) return '0;
        acc = (nn == 1) ? 0 : 1;
        b   = base % nn;
        for (int i = W - 1; i >= 0; i--) begin
            acc = (acc * acc) % nn;
            if (expo[i]) acc = (acc * b) % nn;
        end
        return acc[W-1:0];
    endfunction

    task automatic flag_mismatch(input string what);
        $display("error @%0d: %s", cycle_count, what);
        err_count++;
    endtask

    // waits for the block to go idle, then one apb write
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_pow.size() != 0) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ENC: enc_exp = data[W-1:0];
            REG_DEC: dec_exp = data[W-1:0];
            REG_MOD: mod_n   = data[W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_request(
        input logic         mode,
        input logic [W-1:0] message,
        input bit           typed,
        input logic [W-1:0] typed_value
    );
        t_pow_result rec;
        if (tx_idle_pct > 0 && $urandom_range(0, 3) == 0) begin
            // long gap so the next request lands late in the current job
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 700)) @(posedge i_clk);
        end
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= message;
        i_s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        rec.mode    = mode;
        rec.message = message;
        rec.value   = typed ? typed_value
                            : mod_pow_predict(message, mode ? dec_exp : enc_exp, mod_n);
        pending_pow.push_back(rec);
    endtask

    // result side ready, with one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left       <= HOLD_CYCLES;
            hold_done       <= 1'b1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_pow_result rec;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_pow.size() == 0) begin
                flag_mismatch($sformatf("unexpected result %h", o_m_axis_tdata));
            end else begin
                rec = pending_pow.pop_front();
                if (o_m_axis_tdata !== TDATA_W'(rec.value))
                    flag_mismatch($sformatf("mode %0d msg %h: got %h want %h",
                        rec.mode, rec.message, o_m_axis_tdata, rec.value));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int           ph;
        int           k;
        int           pick;
        logic [W-1:0] ek;
        logic [W-1:0] dk;
        logic [W-1:0] nk;
        logic [W-1:0] msg;

        enc_exp = 1;
        dec_exp = 1;
        mod_n   = 1;
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < DIR_ROWS; k++) begin
            if (dir_tab[k].kind == ROW_CFG)
                reg_write(dir_tab[k].reg_idx, dir_tab[k].wdata);
            else
                send_request(dir_tab[k].mode, dir_tab[k].message,
                             dir_tab[k].kind == ROW_CHK, dir_tab[k].value);
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            ek = (ph == 1) ? '0 : (ph == 3) ? '1 : W'($urandom_range(0, 65535));
            dk = (ph == 5) ? '0 : (ph == 7) ? '1 : W'($urandom_range(0, 65535));
            nk = (ph == 2) ? '1 : (ph == 6) ? W'(1) : (ph == 8) ? W'(2)
                                : W'($urandom_range(2, 65535));
            reg_write(REG_ENC, ($urandom & 32'hFFFF_0000) | ek);
            reg_write(REG_DEC, ($urandom & 32'hFFFF_0000) | dk);
            reg_write(REG_MOD, ($urandom & 32'hFFFF_0000) | nk);

            case (ph % 4)
                1:       begin tx_idle_pct = 82; rx_stall_pct <= 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct <= 82; end
                3:       begin tx_idle_pct = 21; rx_stall_pct <= 21; end
                default: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
            endcase
            if (ph == 4) hold_req <= 1'b1;

            for (k = 0; k < PHASE_REQS; k++) begin
                pick = $urandom_range(0, 15);
                case (pick)
                    0:       msg = '0;
                    1:       msg = '1;
                    2:       msg = mod_n - 1'b1;
                    3:       msg = mod_n;
                    default: msg = W'($urandom_range(0, 65535));
                endcase
                send_request(1'($urandom_range(0, 1)), msg, 1'b0, '0);
            end
        end

        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_pow.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
